// ----- sv/pee_pkg.sv -----
// pee_pkg: types, character codes and arithmetic helpers for the postfix evaluator
// no dependencies; used by every module of the block except pee_div
`default_nettype none
package pee_pkg;

  localparam int DATA_W      = 64;
  localparam int NUM_VARS    = 26;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [3:0] MAX_FRAC_DIGITS = 4'd15;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_Z     = 8'h7a;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;

  localparam logic [63:0] POS_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_DIV0  = 2'd1;
  localparam logic [1:0] STATUS_STACK = 2'd2;

  typedef struct packed {
    logic               func;
    logic [4:0]         letter;
    logic signed [63:0] letter_value;
    logic [7:0]         symbol;
    logic               last_symbol;
  } item_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic [1:0]         status;
  } result_t;

  typedef enum logic [2:0] {
    K_SETVAR,
    K_VAR,
    K_LIT,
    K_OPER,
    K_END
  } kind_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } oper_t;

  typedef struct packed {
    kind_t       kind;
    logic [4:0]  idx;
    oper_t       oper;
    logic [3:0]  fdc;
    logic [63:0] value;
  } entry_t;

  typedef struct packed {
    logic   wr;
    entry_t data;
  } qwr_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ1,
    S_READ2,
    S_EXEC,
    S_MUL,
    S_MFIN,
    S_DIV,
    S_LIT,
    S_PUSH,
    S_END_RD,
    S_OUT
  } state_t;

  function automatic logic [63:0] pow10(input logic [3:0] n);
    logic [63:0] p;
    case (n)
      4'd0:    p = 64'd1;
      4'd1:    p = 64'd10;
      4'd2:    p = 64'd100;
      4'd3:    p = 64'd1000;
      4'd4:    p = 64'd10000;
      4'd5:    p = 64'd100000;
      4'd6:    p = 64'd1000000;
      4'd7:    p = 64'd10000000;
      4'd8:    p = 64'd100000000;
      4'd9:    p = 64'd1000000000;
      4'd10:   p = 64'd10000000000;
      4'd11:   p = 64'd100000000000;
      4'd12:   p = 64'd1000000000000;
      4'd13:   p = 64'd10000000000000;
      4'd14:   p = 64'd100000000000000;
      default: p = 64'd1000000000000000;
    endcase
    return p;
  endfunction

  function automatic logic [63:0] magnitude(input logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic [63:0] signed_sat(input logic neg, input logic [63:0] mag,
                                             input logic ovf);
    logic [63:0] r;
    if (neg) begin
      if (ovf || mag > NEG_MIN) r = NEG_MIN;
      else r = ~mag + 64'd1;
    end else begin
      if (ovf || mag > POS_MAX) r = POS_MAX;
      else r = mag;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/postfix_expression_evaluator.sv -----
// postfix expression evaluator, signed fixed point, front/queue/back organisation
// literals are scaled and / is computed by the one-bit-per-cycle shared divider
// throughput: digits and dots one word per cycle while no command is pending; a word that
// issues commands stalls the input until all of them have entered the 4-entry queue
// reset: synchronous; clears control state, the queue and the variable valid bits
`default_nettype none
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = 16,
  parameter int FRAC_BITS   = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire pee_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output pee_pkg::result_t      result
);

  pee_pkg::qwr_t   q_wr;
  logic            q_full;
  logic            q_rd;
  logic            q_empty;
  pee_pkg::entry_t q_data;

  pee_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_full     (q_full),
    .q_wr       (q_wr)
  );

  pee_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .full    (q_full),
    .rd      (q_rd),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  pee_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (q_data),
    .q_rd         (q_rd),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != pee_pkg::STATUS_OK |-> result.result_value == '0)
    else $error("error word carries a nonzero value");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.status <= pee_pkg::STATUS_STACK)
    else $error("undefined status code");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("block not idle after reset");

endmodule
`default_nettype wire

// ----- sv/pee_queue.sv -----
// pee_queue: short command queue between the front and the back
// depends on pee_pkg
`default_nettype none
module pee_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire pee_pkg::qwr_t   wr,
  output logic                 full,
  input  wire logic            rd,
  output pee_pkg::entry_t      rd_data,
  output logic                 empty
);

  localparam int AW = $clog2(pee_pkg::QUEUE_DEPTH);

  pee_pkg::entry_t slots [pee_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   fill;

  assign full    = (fill == (AW+1)'(pee_pkg::QUEUE_DEPTH));
  assign empty   = (fill == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr.wr && !full) slots[wr_ptr] <= wr.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr.wr && !full) wr_ptr <= wr_ptr + AW'(1);
      if (rd && !empty) rd_ptr <= rd_ptr + AW'(1);
      fill <= fill + (AW+1)'(wr.wr && !full) - (AW+1)'(rd && !empty);
    end
  end

endmodule
`default_nettype wire

// ----- sv/pee_front.sv -----
// pee_front: takes words, builds decimal literals and issues commands to the queue
// depends on pee_pkg
`default_nettype none
module pee_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_stall,
  input  wire pee_pkg::item_t item,
  input  wire logic           q_full,
  output pee_pkg::qwr_t       q_wr
);

  logic pend_lit, pend_main, pend_end;
  logic pend_lit_next, pend_main_next, pend_end_next;
  pee_pkg::entry_t main_e, main_e_next;
  logic [63:0] lit_mant, lit_mant_next;
  logic [3:0]  lit_fdc, lit_fdc_next;
  logic        in_number, in_number_next;
  logic        seen_dot, seen_dot_next;
  logic [63:0] acc, acc_next;
  logic [3:0]  fdc, fdc_next;

  logic        busy, take;
  logic [7:0]  c;
  logic        is_digit, is_dot, is_letter, is_op;
  logic [63:0] base_acc, acc_dig;
  logic [3:0]  base_fdc;
  logic        base_dot;
  logic [67:0] wide;
  logic        n_in, n_dot, close;
  logic [63:0] n_acc;
  logic [3:0]  n_fdc;
  logic [7:0]  letter_off;
  pee_pkg::entry_t lit_e, end_e;

  assign busy       = pend_lit | pend_main | pend_end;
  assign item_stall = busy;
  assign take       = item_valid & ~busy;

  assign c          = item.symbol;
  assign is_digit   = c inside {[pee_pkg::CH_ZERO:pee_pkg::CH_NINE]};
  assign is_dot     = (c == pee_pkg::CH_DOT);
  assign is_letter  = c inside {[pee_pkg::CH_A:pee_pkg::CH_Z]};
  assign is_op      = c inside {pee_pkg::CH_PLUS, pee_pkg::CH_MINUS, pee_pkg::CH_STAR,
                                pee_pkg::CH_SLASH};
  assign letter_off = c - pee_pkg::CH_A;

  assign base_acc = in_number ? acc : '0;
  assign base_fdc = in_number ? fdc : '0;
  assign base_dot = in_number & seen_dot;
  assign wide     = ({4'b0, base_acc} << 3) + ({4'b0, base_acc} << 1) + {64'b0, c[3:0]};
  assign acc_dig  = (|wide[67:64]) ? '1 : wide[63:0];

  always_comb begin
    lit_e       = '0;
    lit_e.kind  = pee_pkg::K_LIT;
    lit_e.fdc   = lit_fdc;
    lit_e.value = lit_mant;
    end_e       = '0;
    end_e.kind  = pee_pkg::K_END;
  end

  always_comb begin
    q_wr.wr   = busy & ~q_full;
    q_wr.data = pend_lit ? lit_e : (pend_main ? main_e : end_e);
  end

  always_comb begin
    pend_lit_next  = pend_lit;
    pend_main_next = pend_main;
    pend_end_next  = pend_end;
    main_e_next    = main_e;
    lit_mant_next  = lit_mant;
    lit_fdc_next   = lit_fdc;
    in_number_next = in_number;
    seen_dot_next  = seen_dot;
    acc_next       = acc;
    fdc_next       = fdc;
    n_in  = in_number;
    n_acc = acc;
    n_fdc = fdc;
    n_dot = seen_dot;
    close = 1'b0;

    if (q_wr.wr) begin
      if (pend_lit) pend_lit_next = 1'b0;
      else if (pend_main) pend_main_next = 1'b0;
      else pend_end_next = 1'b0;
    end

    if (take) begin
      if (!item.func) begin
        if (item.letter < 5'(pee_pkg::NUM_VARS)) begin
          pend_main_next    = 1'b1;
          main_e_next       = '0;
          main_e_next.kind  = pee_pkg::K_SETVAR;
          main_e_next.idx   = item.letter;
          main_e_next.value = item.letter_value;
        end
      end else begin
        if (is_digit) begin
          n_in  = 1'b1;
          n_dot = base_dot;
          if (!base_dot || base_fdc < pee_pkg::MAX_FRAC_DIGITS) begin
            n_acc = acc_dig;
            n_fdc = base_fdc + 4'(base_dot);
          end else begin
            n_acc = base_acc;
            n_fdc = base_fdc;
          end
        end else if (is_dot) begin
          if (in_number) n_dot = 1'b1;
        end
        close = n_in & (~(is_digit | is_dot) | item.last_symbol);
        if (close) begin
          pend_lit_next  = 1'b1;
          lit_mant_next  = n_acc;
          lit_fdc_next   = n_fdc;
          in_number_next = 1'b0;
          seen_dot_next  = 1'b0;
          acc_next       = '0;
          fdc_next       = '0;
        end else begin
          in_number_next = n_in;
          seen_dot_next  = n_dot;
          acc_next       = n_acc;
          fdc_next       = n_fdc;
        end
        if (is_letter) begin
          pend_main_next   = 1'b1;
          main_e_next      = '0;
          main_e_next.kind = pee_pkg::K_VAR;
          main_e_next.idx  = letter_off[4:0];
        end else if (is_op) begin
          pend_main_next   = 1'b1;
          main_e_next      = '0;
          main_e_next.kind = pee_pkg::K_OPER;
          case (c)
            pee_pkg::CH_PLUS:  main_e_next.oper = pee_pkg::OP_ADD;
            pee_pkg::CH_MINUS: main_e_next.oper = pee_pkg::OP_SUB;
            pee_pkg::CH_STAR:  main_e_next.oper = pee_pkg::OP_MUL;
            default:           main_e_next.oper = pee_pkg::OP_DIV;
          endcase
        end
        pend_end_next = item.last_symbol;
      end
    end
  end

  always_ff @(posedge clk) begin
    main_e   <= main_e_next;
    lit_mant <= lit_mant_next;
    lit_fdc  <= lit_fdc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_lit  <= 1'b0;
      pend_main <= 1'b0;
      pend_end  <= 1'b0;
      in_number <= 1'b0;
      seen_dot  <= 1'b0;
      acc       <= '0;
      fdc       <= '0;
    end else begin
      pend_lit  <= pend_lit_next;
      pend_main <= pend_main_next;
      pend_end  <= pend_end_next;
      in_number <= in_number_next;
      seen_dot  <= seen_dot_next;
      acc       <= acc_next;
      fdc       <= fdc_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/pee_div.sv -----
// pee_div: restoring divider, one quotient bit per cycle
// shared by literal scaling and the divide operator; no package use
`default_nettype none
module pee_div #(
  parameter int W = 96
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [63:0]  divisor,
  output logic              done,
  output logic [W-1:0]      quotient
);

  localparam int CW = $clog2(W + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  num;
  logic [63:0]   rem;
  logic [63:0]   dsr;
  logic [64:0]   trial;
  logic          fits;

  assign trial = {rem, num[W-1]};
  assign fits  = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (start) begin
      num      <= dividend;
      rem      <= '0;
      dsr      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      num      <= num << 1;
      rem      <= fits ? 64'(trial - {1'b0, dsr}) : trial[63:0];
      quotient <= {quotient[W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/pee_back.sv -----
// pee_back: executes queued commands on the operand stack and the variable table
// depends on pee_pkg and pee_div
`default_nettype none
module pee_back #(
  parameter int STACK_DEPTH = 16,
  parameter int FRAC_BITS   = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_empty,
  input  wire pee_pkg::entry_t q_data,
  output logic                 q_rd,
  output logic                 result_valid,
  input  wire logic            result_stall,
  output pee_pkg::result_t     result
);

  localparam int DIV_W = pee_pkg::DATA_W + FRAC_BITS;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int AW    = $clog2(STACK_DEPTH);

  pee_pkg::state_t state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [1:0]  err, err_next;
  logic [63:0] var_val [pee_pkg::NUM_VARS];
  logic [pee_pkg::NUM_VARS-1:0] var_ok, var_ok_next;
  logic        var_we;
  logic [63:0] yv, yv_next, zv, zv_next, res, res_next;
  logic [1:0]  stat, stat_next;
  pee_pkg::oper_t oper, oper_next;
  logic [127:0] macc;
  logic [63:0]  prod;
  logic [2:0]   mstep;
  logic [1:0]   pstep;
  logic [31:0]  mul_a, mul_b;
  logic [63:0]  xm, wm;
  logic         neg;
  logic [63:0]  sum, diff;

  logic [63:0]  stack_mem [STACK_DEPTH];
  logic         mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [63:0]  rd_q;

  logic             div_start, div_done;
  logic [DIV_W-1:0] div_dividend, div_q;
  logic [63:0]      div_divisor;

  logic out_load;
  logic out_valid;
  pee_pkg::result_t out_reg;

  pee_div #(.W(DIV_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign xm    = pee_pkg::magnitude(yv);
  assign wm    = pee_pkg::magnitude(zv);
  assign neg   = yv[63] ^ zv[63];
  assign sum   = yv + zv;
  assign diff  = yv - zv;
  assign mul_a = mstep[0] ? xm[63:32] : xm[31:0];
  assign mul_b = mstep[1] ? wm[63:32] : wm[31:0];
  assign pstep = 2'(mstep - 3'd1);

  assign result       = out_reg;
  assign result_valid = out_valid;

  always_comb begin
    state_next   = state;
    count_next   = count;
    err_next     = err;
    var_ok_next  = var_ok;
    var_we       = 1'b0;
    yv_next      = yv;
    zv_next      = zv;
    res_next     = res;
    stat_next    = stat;
    oper_next    = oper;
    q_rd         = 1'b0;
    mem_we       = 1'b0;
    mem_wa       = count[AW-1:0];
    mem_ra       = AW'(count - CNT_W'(1));
    div_start    = 1'b0;
    div_dividend = {q_data.value, {FRAC_BITS{1'b0}}};
    div_divisor  = pee_pkg::pow10(q_data.fdc);
    out_load     = 1'b0;

    case (state)
      pee_pkg::S_IDLE: begin
        if (!q_empty) begin
          q_rd = 1'b1;
          case (q_data.kind)
            pee_pkg::K_SETVAR: begin
              var_we = 1'b1;
              var_ok_next[q_data.idx] = 1'b1;
            end
            pee_pkg::K_VAR: begin
              if (err == pee_pkg::STATUS_OK) begin
                res_next   = var_ok[q_data.idx] ? var_val[q_data.idx] : '0;
                state_next = pee_pkg::S_PUSH;
              end
            end
            pee_pkg::K_LIT: begin
              if (err == pee_pkg::STATUS_OK) begin
                div_start  = 1'b1;
                state_next = pee_pkg::S_LIT;
              end
            end
            pee_pkg::K_OPER: begin
              if (err == pee_pkg::STATUS_OK) begin
                if (count < CNT_W'(2)) begin
                  err_next = pee_pkg::STATUS_STACK;
                end else begin
                  oper_next  = q_data.oper;
                  state_next = pee_pkg::S_READ1;
                end
              end
            end
            default: begin
              if (err != pee_pkg::STATUS_OK) begin
                res_next   = '0;
                stat_next  = err;
                state_next = pee_pkg::S_OUT;
              end else if (count == '0) begin
                res_next   = '0;
                stat_next  = pee_pkg::STATUS_STACK;
                state_next = pee_pkg::S_OUT;
              end else begin
                state_next = pee_pkg::S_END_RD;
              end
            end
          endcase
        end
      end
      pee_pkg::S_READ1: begin
        zv_next    = rd_q;
        mem_ra     = AW'(count - CNT_W'(2));
        state_next = pee_pkg::S_READ2;
      end
      pee_pkg::S_READ2: begin
        yv_next    = rd_q;
        count_next = count - CNT_W'(2);
        state_next = pee_pkg::S_EXEC;
      end
      pee_pkg::S_EXEC: begin
        case (oper)
          pee_pkg::OP_ADD: begin
            res_next = sum;
            if (yv[63] == zv[63] && sum[63] != yv[63])
              res_next = yv[63] ? pee_pkg::NEG_MIN : pee_pkg::POS_MAX;
            state_next = pee_pkg::S_PUSH;
          end
          pee_pkg::OP_SUB: begin
            res_next = diff;
            if (yv[63] != zv[63] && diff[63] != yv[63])
              res_next = yv[63] ? pee_pkg::NEG_MIN : pee_pkg::POS_MAX;
            state_next = pee_pkg::S_PUSH;
          end
          pee_pkg::OP_MUL: begin
            state_next = pee_pkg::S_MUL;
          end
          default: begin
            if (zv == '0) begin
              err_next   = pee_pkg::STATUS_DIV0;
              state_next = pee_pkg::S_IDLE;
            end else begin
              div_start    = 1'b1;
              div_dividend = {xm, {FRAC_BITS{1'b0}}};
              div_divisor  = wm;
              state_next   = pee_pkg::S_DIV;
            end
          end
        endcase
      end
      pee_pkg::S_MUL: begin
        if (mstep == 3'd4) state_next = pee_pkg::S_MFIN;
      end
      pee_pkg::S_MFIN: begin
        res_next   = pee_pkg::signed_sat(neg, macc[FRAC_BITS +: 64],
                                         |macc[127:64+FRAC_BITS]);
        state_next = pee_pkg::S_PUSH;
      end
      pee_pkg::S_DIV: begin
        if (div_done) begin
          res_next   = pee_pkg::signed_sat(neg, div_q[63:0], |div_q[DIV_W-1:64]);
          state_next = pee_pkg::S_PUSH;
        end
      end
      pee_pkg::S_LIT: begin
        if (div_done) begin
          res_next   = (|div_q[DIV_W-1:63]) ? pee_pkg::POS_MAX : div_q[63:0];
          state_next = pee_pkg::S_PUSH;
        end
      end
      pee_pkg::S_PUSH: begin
        if (count >= CNT_W'(STACK_DEPTH)) begin
          err_next = pee_pkg::STATUS_STACK;
        end else begin
          mem_we     = 1'b1;
          count_next = count + CNT_W'(1);
        end
        state_next = pee_pkg::S_IDLE;
      end
      pee_pkg::S_END_RD: begin
        res_next   = rd_q;
        stat_next  = pee_pkg::STATUS_OK;
        state_next = pee_pkg::S_OUT;
      end
      pee_pkg::S_OUT: begin
        if (!out_valid || !result_stall) begin
          out_load    = 1'b1;
          count_next  = '0;
          err_next    = pee_pkg::STATUS_OK;
          var_ok_next = '0;
          state_next  = pee_pkg::S_IDLE;
        end
      end
      default: state_next = pee_pkg::S_IDLE;
    endcase
  end

  // operand stack
  always_ff @(posedge clk) begin
    if (mem_we) stack_mem[mem_wa] <= res;
    rd_q <= stack_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (var_we) var_val[q_data.idx] <= q_data.value;
  end

  // four 32x32 partial products, each registered before accumulation
  always_ff @(posedge clk) begin
    if (state != pee_pkg::S_MUL) begin
      mstep <= '0;
      macc  <= '0;
    end else begin
      mstep <= mstep + 3'd1;
      if (mstep != 3'd4) prod <= mul_a * mul_b;
      if (mstep != 3'd0) begin
        case (pstep)
          2'd0:    macc <= macc + {64'b0, prod};
          2'd3:    macc <= macc + {prod, 64'b0};
          default: macc <= macc + {32'b0, prod, 32'b0};
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    yv   <= yv_next;
    zv   <= zv_next;
    res  <= res_next;
    stat <= stat_next;
    oper <= oper_next;
    if (out_load) begin
      out_reg.result_value <= res;
      out_reg.status       <= stat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pee_pkg::S_IDLE;
      count     <= '0;
      err       <= pee_pkg::STATUS_OK;
      var_ok    <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      err       <= err_next;
      var_ok    <= var_ok_next;
      out_valid <= out_load | (out_valid & result_stall);
    end
  end

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
// tb_top: self-checking testbench for postfix_expression_evaluator
// drives expression words with random idling and random result stalls and compares each result against
// an internal fixed-point evaluator; depends on pee_pkg and the block itself
`default_nettype none
module tb_top;

  localparam int STK = 16;
  localparam int FB  = 32;

  class expr_scoreboard;
    logic [63:0] stk [STK];
    int unsigned depth;
    logic [63:0] vars [pee_pkg::NUM_VARS];
    logic [63:0] mant;
    int unsigned fdc;
    bit          in_num, dot;
    logic [1:0]  err;
    pee_pkg::result_t pending [$];
    int          errors, checked;

    function void clear_expr();
      depth = 0; mant = 0; fdc = 0; in_num = 0; dot = 0; err = pee_pkg::STATUS_OK;
    endfunction

    function void clear_all();
      clear_expr();
      foreach (vars[i]) vars[i] = '0;
    endfunction

    function void flag(logic [1:0] c);
      if (err == pee_pkg::STATUS_OK) err = c;
    endfunction

    function void push(logic [63:0] v);
      if (err != pee_pkg::STATUS_OK) return;
      if (depth >= STK) begin
        flag(pee_pkg::STATUS_STACK);
        return;
      end
      stk[depth] = v;
      depth++;
    endfunction

    function logic [63:0] mag(logic [63:0] v);
      return v[63] ? -v : v;
    endfunction

    function logic [63:0] sat(bit neg, logic [63:0] m, bit ovf);
      if (neg) return (ovf || m > pee_pkg::NEG_MIN) ? pee_pkg::NEG_MIN : -m;
      return (ovf || m > pee_pkg::POS_MAX) ? pee_pkg::POS_MAX : m;
    endfunction

    function logic [63:0] times(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, mag(a)} * {64'd0, mag(b)};
      return sat(a[63] ^ b[63], p[FB +: 64], p[127:FB+64] != 0);
    endfunction

    function logic [63:0] quot(logic [63:0] a, logic [63:0] b);
      logic [127:0] n, q;
      n = {64'd0, mag(a)} << FB;
      q = n / {64'd0, mag(b)};
      return sat(a[63] ^ b[63], q[63:0], q[127:64] != 0);
    endfunction

    function void close_literal();
      logic [63:0] p, ip, v;
      logic [127:0] fr;
      if (!in_num) return;
      in_num = 0; dot = 0;
      p = 64'd1;
      for (int i = 0; i < fdc; i++) p = p * 64'd10;
      ip = mant / p;
      fr = ({64'd0, mant % p} << FB) / {64'd0, p};
      if (ip > (pee_pkg::POS_MAX >> FB)) v = pee_pkg::POS_MAX;
      else v = (ip << FB) | fr[63:0];
      mant = 0; fdc = 0;
      push(v);
    endfunction

    function void operate(logic [7:0] c);
      logic [63:0] y, z, r;
      if (err != pee_pkg::STATUS_OK) return;
      if (depth < 2) begin
        flag(pee_pkg::STATUS_STACK);
        return;
      end
      z = stk[depth-1];
      y = stk[depth-2];
      depth -= 2;
      case (c)
        pee_pkg::CH_PLUS: begin
          r = y + z;
          if (y[63] == z[63] && r[63] != y[63])
            r = y[63] ? pee_pkg::NEG_MIN : pee_pkg::POS_MAX;
        end
        pee_pkg::CH_MINUS: begin
          r = y - z;
          if (y[63] != z[63] && r[63] != y[63])
            r = y[63] ? pee_pkg::NEG_MIN : pee_pkg::POS_MAX;
        end
        pee_pkg::CH_STAR: r = times(y, z);
        default: begin
          if (z == 0) begin
            flag(pee_pkg::STATUS_DIV0);
            return;
          end
          r = quot(y, z);
        end
      endcase
      push(r);
    endfunction

    function void note_item(pee_pkg::item_t it);
      logic [7:0] c;
      logic [64:0] t;
      pee_pkg::result_t e;
      if (!it.func) begin
        if (it.letter < 5'(pee_pkg::NUM_VARS)) vars[it.letter] = it.letter_value;
        return;
      end
      c = it.symbol;
      if (c >= pee_pkg::CH_ZERO && c <= pee_pkg::CH_NINE) begin
        if (!in_num) begin
          in_num = 1; dot = 0; mant = 0; fdc = 0;
        end
        if (!dot || fdc < pee_pkg::MAX_FRAC_DIGITS) begin
          t = {1'b0, mant} * 65'd10 + 65'(c - pee_pkg::CH_ZERO);
          mant = (t[64] || mant > 64'h1999_9999_9999_9999) ? '1 : t[63:0];
          if (dot) fdc++;
        end
      end else if (c == pee_pkg::CH_DOT) begin
        if (in_num) dot = 1;
      end else begin
        close_literal();
        if (c >= pee_pkg::CH_A && c <= pee_pkg::CH_Z) push(vars[c - pee_pkg::CH_A]);
        else if (c == pee_pkg::CH_PLUS || c == pee_pkg::CH_MINUS ||
                 c == pee_pkg::CH_STAR || c == pee_pkg::CH_SLASH)
          operate(c);
      end
      if (!it.last_symbol) return;
      close_literal();
      if (err != pee_pkg::STATUS_OK) e = '{64'd0, err};
      else if (depth == 0) e = '{64'd0, pee_pkg::STATUS_STACK};
      else e = '{stk[depth-1], pee_pkg::STATUS_OK};
      pending.push_back(e);
      clear_all();
    endfunction

    function void check_result(pee_pkg::result_t r);
      pee_pkg::result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result value %h status %0d", $time,
                 r.result_value, r.status);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (r.result_value !== e.result_value) begin
        $display("%0t: value mismatch expected %h actual %h", $time,
                 e.result_value, r.result_value);
        errors++;
      end
      if (r.status !== e.status) begin
        $display("%0t: status mismatch expected %0d actual %0d", $time,
                 e.status, r.status);
        errors++;
      end
    endfunction
  endclass

  logic    clk = 0;
  logic    rst = 1;
  logic    item_valid = 0;
  logic    item_stall;
  pee_pkg::item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 0;
  pee_pkg::result_t result;

  expr_scoreboard sb = new();
  int send_idle = 0, recv_stall = 0;
  bit hold_off = 0;
  int sent = 0, ops_seen = 0;

  postfix_expression_evaluator uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
    if (hold_off) result_stall <= 1;
    else result_stall <= ($urandom_range(99) < recv_stall);
  end

  task automatic send(pee_pkg::item_t it);
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 0;
      @(posedge clk);
    end
    item_valid <= 1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_item(it);
    sent++;
  endtask

  task automatic ch(logic [7:0] c, bit last = 0);
    pee_pkg::item_t it;
    it = '0;
    it.func = 1;
    it.symbol = c;
    it.last_symbol = last;
    it.letter = 5'($urandom);
    it.letter_value = {$urandom, $urandom};
    send(it);
  endtask

  task automatic setvar(logic [4:0] l, logic [63:0] v, bit last = 0);
    pee_pkg::item_t it;
    it = '0;
    it.letter = l;
    it.letter_value = v;
    it.last_symbol = last;
    it.symbol = 8'($urandom);
    send(it);
  endtask

  task automatic str(string s);
    for (int i = 0; i < s.len(); i++) ch(s[i], i == s.len() - 1);
  endtask

  task automatic drain();
    item_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_val();
    case ($urandom_range(5))
      0: return pee_pkg::POS_MAX;
      1: return pee_pkg::NEG_MIN;
      2: return 64'd0;
      3: return {{32{$urandom_range(1) == 1}}, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [7:0] rand_oper();
    case ($urandom_range(3))
      0: return pee_pkg::CH_PLUS;
      1: return pee_pkg::CH_MINUS;
      2: return pee_pkg::CH_STAR;
      default: return pee_pkg::CH_SLASH;
    endcase
  endfunction

  task automatic rand_literal();
    int n;
    n = ($urandom_range(4) == 0) ? int'($urandom_range(25)) : int'($urandom_range(5, 1));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(6) == 0) ch(pee_pkg::CH_DOT);
      ch(8'(pee_pkg::CH_ZERO + $urandom_range(9)));
    end
  endtask

  task automatic rand_expression();
    int d, nops;
    logic [4:0] l;
    d = 0;
    nops = ($urandom_range(20) == 0) ? 18 : int'($urandom_range(6));
    for (int i = 0; i < $urandom_range(3); i++) begin
      l = 5'($urandom_range(pee_pkg::NUM_VARS - 1));
      setvar(l, rand_val());
    end
    if ($urandom_range(30) == 0) setvar(5'($urandom_range(31, 26)), rand_val());
    while (nops > 0) begin
      if (d >= 2 && ($urandom_range(1) == 1 || d >= STK)) begin
        ch(rand_oper());
        ops_seen++;
        d--;
        nops--;
      end else begin
        if ($urandom_range(1) == 1) rand_literal();
        else ch(8'(pee_pkg::CH_A + $urandom_range(25)));
        ch(($urandom_range(3) == 0) ? pee_pkg::CH_DOT : 8'h20);
        d++;
      end
      if ($urandom_range(25) == 0) ch(8'($urandom));
      if ($urandom_range(40) == 0) ch(rand_oper());
    end
    if ($urandom_range(15) == 0) setvar(5'($urandom), rand_val(), 1);
    ch(($urandom_range(3) == 0) ? 8'(pee_pkg::CH_ZERO + $urandom_range(9)) : 8'h20, 1);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed words
    setvar(5'd0, pee_pkg::POS_MAX);
    setvar(5'd1, pee_pkg::NEG_MIN);
    setvar(5'd25, 64'h0000_0001_0000_0000);
    setvar(5'd31, 64'hffff_ffff_ffff_ffff);
    str("ab+z-ab*z/ *+ ");
    str("3.75 .2..5 / ");
    str("99999999999999999999999 0.1234567890123456789 + ");
    str("a 0 /");
    str("+ ");
    str(" ");
    str("12");
    // one push more than the stack holds
    for (int i = 0; i < STK + 1; i++) begin
      ch(pee_pkg::CH_ZERO + 8'd1);
      ch(8'h20);
    end
    ch(8'hff, 1);
    drain();
    // random phases
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 82; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 82; end
        3: begin send_idle = 8;  recv_stall = 8;  end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      if (ph == 4) begin
        hold_off = 1;
        fork
          begin
            repeat (3000) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      while (sent < 290 * (ph + 1)) begin
        rand_expression();
        if ($urandom_range(40) == 0) drain();
      end
      drain();
    end
    $display("covered %0d words over directed cases and five idling phases", sent);
    $display("%0d operators issued, %0d results checked", ops_seen, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire
